@@ hdl/afrc_pkg.sv @@
`default_nettype none
package afrc_pkg;

    // frame layout
    localparam int unsigned CHANNELS     = 4;
    localparam int unsigned COUNTER_BITS = 32;
    localparam int unsigned WORD_BYTES   = 3;
    localparam int unsigned FRAME_WORDS  = CHANNELS + 2;
    localparam int unsigned WORD_BITS    = $clog2(FRAME_WORDS);
    localparam int unsigned SUB_BITS     = $clog2(WORD_BYTES);
    localparam int unsigned CHAN_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // result packing, lowest bit first
    localparam int unsigned OUT_CHANNELS = 4;
    localparam int unsigned RESP_W       = 16;
    localparam int unsigned SAMPLE_W     = 24;
    localparam int unsigned CRC_W        = 16;
    localparam int unsigned COUNT_OUT_W  = 32;
    localparam int unsigned OFF_RESP     = 0;
    localparam int unsigned OFF_CH0      = OFF_RESP + RESP_W;
    localparam int unsigned OFF_CRC_RX   = OFF_CH0 + OUT_CHANNELS * SAMPLE_W;
    localparam int unsigned OFF_CRC_COMP = OFF_CRC_RX + CRC_W;
    localparam int unsigned OFF_CRC_OK   = OFF_CRC_COMP + CRC_W;
    localparam int unsigned OFF_FRAMES   = OFF_CRC_OK + 1;
    localparam int unsigned OFF_FAILS    = OFF_FRAMES + COUNT_OUT_W;
    localparam int unsigned RESULT_BITS  = OFF_FAILS + COUNT_OUT_W;
    localparam int unsigned TDATA_BITS   = ((RESULT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FIELD_RESPONSE,
        FIELD_CHANNEL,
        FIELD_CRC
    } field_t;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]          data;
        logic                seed;
        logic                crc_en;
        field_t              field;
        logic [CHAN_BITS-1:0] chan;
        logic [SUB_BITS-1:0] sub;
        logic                last;
    } byte_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/afrc_front.sv @@
`default_nettype none
module afrc_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [7:0]              s_tdata,   // rx_byte
    input  wire logic [0:0]              s_tuser,   // frame_start
    input  wire afrc_pkg::queue_status_t q_status,
    output logic                         push,
    output afrc_pkg::byte_cmd_t          cmd
);
    import afrc_pkg::*;

    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [SUB_BITS-1:0]  sub_reg, sub_next;
    logic [WORD_BITS-1:0] word_cur;
    logic [SUB_BITS-1:0]  sub_cur;
    logic [WORD_BITS-1:0] chan_wide;

    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // frame start forces position back to byte 0
    assign word_cur  = s_tuser[0] ? '0 : word_reg;
    assign sub_cur   = s_tuser[0] ? '0 : sub_reg;
    assign chan_wide = word_cur - WORD_BITS'(1);

    always_comb begin
        cmd.data   = s_tdata;
        cmd.seed   = (word_cur == '0) && (sub_cur == '0);
        cmd.crc_en = (word_cur <= WORD_BITS'(CHANNELS));
        cmd.chan   = chan_wide[CHAN_BITS-1:0];
        cmd.sub    = sub_cur;
        cmd.last   = (word_cur == WORD_BITS'(FRAME_WORDS - 1)) &&
                     (sub_cur == SUB_BITS'(WORD_BYTES - 1));
        if (word_cur == '0) begin
            cmd.field = FIELD_RESPONSE;
        end else if (word_cur == WORD_BITS'(FRAME_WORDS - 1)) begin
            cmd.field = FIELD_CRC;
        end else begin
            cmd.field = FIELD_CHANNEL;
        end

        word_next = word_reg;
        sub_next  = sub_reg;
        if (push) begin
            if (cmd.last) begin
                word_next = '0;
                sub_next  = '0;
            end else if (sub_cur == SUB_BITS'(WORD_BYTES - 1)) begin
                word_next = word_cur + WORD_BITS'(1);
                sub_next  = '0;
            end else begin
                word_next = word_cur;
                sub_next  = sub_cur + SUB_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
            sub_reg  <= '0;
        end else begin
            word_reg <= word_next;
            sub_reg  <= sub_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/afrc_queue.sv @@
`default_nettype none
module afrc_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire afrc_pkg::byte_cmd_t push_cmd,
    input  wire logic                pop,
    output afrc_pkg::byte_cmd_t      head_cmd,
    output afrc_pkg::queue_status_t  status
);
    import afrc_pkg::*;

    byte_cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;
    logic                   do_push, do_pop;

    assign status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ hdl/afrc_back.sv @@
`default_nettype none
module afrc_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire afrc_pkg::queue_status_t             q_status,
    input  wire afrc_pkg::byte_cmd_t                 cmd,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [afrc_pkg::TDATA_BITS-1:0]          m_tdata
);
    import afrc_pkg::*;

    logic [15:0]             crc_reg, crc_next;
    logic [15:0]             crc_cur, crc_new;
    logic [RESP_W-1:0]       resp_reg;
    logic [SAMPLE_W-1:0]     chan_reg [CHANNELS];
    logic [CRC_W-1:0]        crc_rx_reg;
    logic [COUNTER_BITS-1:0] frame_cnt_reg, frame_cnt_next;
    logic [COUNTER_BITS-1:0] err_cnt_reg, err_cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [TDATA_BITS-1:0]   m_tdata_reg, m_tdata_next;
    logic [SAMPLE_W-1:0]     sample_slot [OUT_CHANNELS];
    logic                    crc_ok;
    logic                    emit;

    // a last byte needs the output register free or draining
    assign pop  = !q_status.empty && (!cmd.last || !m_tvalid_reg || m_tready);
    assign emit = pop && cmd.last;

    assign crc_cur = cmd.seed ? CRC_SEED : crc_reg;
    assign crc_new = cmd.crc_en ? crc_byte(crc_cur, cmd.data) : crc_cur;
    assign crc_ok  = (crc_rx_reg == crc_new);

    for (genvar c = 0; c < OUT_CHANNELS; c++) begin : g_slot
        if (c < CHANNELS) begin : g_used
            assign sample_slot[c] = chan_reg[c];
        end else begin : g_unused
            assign sample_slot[c] = '0;
        end
    end

    always_comb begin
        crc_next       = pop ? crc_new : crc_reg;
        frame_cnt_next = frame_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        if (emit) begin
            frame_cnt_next = frame_cnt_reg + COUNTER_BITS'(1);
            if (!crc_ok) begin
                err_cnt_next = err_cnt_reg + COUNTER_BITS'(1);
            end
        end

        m_tdata_next = '0;
        m_tdata_next[OFF_RESP +: RESP_W] = resp_reg;
        for (int c = 0; c < OUT_CHANNELS; c++) begin
            m_tdata_next[OFF_CH0 + c * SAMPLE_W +: SAMPLE_W] = sample_slot[c];
        end
        m_tdata_next[OFF_CRC_RX +: CRC_W]        = crc_rx_reg;
        m_tdata_next[OFF_CRC_COMP +: CRC_W]      = crc_new;
        m_tdata_next[OFF_CRC_OK]                 = crc_ok;
        m_tdata_next[OFF_FRAMES +: COUNT_OUT_W]  = COUNT_OUT_W'(frame_cnt_next);
        m_tdata_next[OFF_FAILS +: COUNT_OUT_W]   = COUNT_OUT_W'(err_cnt_next);

        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_SEED;
            frame_cnt_reg <= '0;
            err_cnt_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            frame_cnt_reg <= frame_cnt_next;
            err_cnt_reg   <= err_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // field capture, most significant byte first
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= m_tdata_next;
        end
        if (pop) begin
            unique case (cmd.field)
                FIELD_RESPONSE: begin
                    if (cmd.sub == SUB_BITS'(0)) begin
                        resp_reg[15:8] <= cmd.data;
                    end else if (cmd.sub == SUB_BITS'(1)) begin
                        resp_reg[7:0] <= cmd.data;
                    end
                end
                FIELD_CHANNEL: begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (cmd.chan == CHAN_BITS'(c)) begin
                            if (cmd.sub == SUB_BITS'(0)) begin
                                chan_reg[c][23:16] <= cmd.data;
                            end else if (cmd.sub == SUB_BITS'(1)) begin
                                chan_reg[c][15:8] <= cmd.data;
                            end else begin
                                chan_reg[c][7:0] <= cmd.data;
                            end
                        end
                    end
                end
                FIELD_CRC: begin
                    if (cmd.sub == SUB_BITS'(0)) begin
                        crc_rx_reg[15:8] <= cmd.data;
                    end else if (cmd.sub == SUB_BITS'(1)) begin
                        crc_rx_reg[7:0] <= cmd.data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

@@ hdl/adc_frame_receiver_crc16.sv @@
`default_nettype none
// ADC frame receiver: takes one received frame byte per item (frame_start in
// s_tuser restarts the frame at that byte) and, after the eighteenth byte of a
// frame, delivers one result with the response word, four 24-bit samples,
// received and computed CRC-16/CCITT-FALSE, the match flag and wrapping frame
// and CRC-failure counts. A byte is accepted every cycle while the result side
// keeps up; the last byte of a frame passes through the queue, and m_tvalid is
// registered when the back stage takes it. Throughput is set by the byte-wide
// CRC update in the back stage, one byte per clock while no last byte waits on
// the output; a two-item queue between classifier and back stage absorbs stalls.
module adc_frame_receiver_crc16 (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // [7:0] rx_byte
    input  wire logic [0:0]                       s_tuser,  // [0] frame_start
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // response_word, sample_ch0..3, crc_received, crc_computed, crc_ok,
    // frames_seen, crc_failures; zero fill to 216 bits
    output logic [afrc_pkg::TDATA_BITS-1:0]       m_tdata
);
    import afrc_pkg::*;

    queue_status_t q_status;
    byte_cmd_t     push_cmd;
    byte_cmd_t     head_cmd;
    logic          push;
    logic          pop;

    afrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    afrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    afrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .cmd      (head_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_crc_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OFF_CRC_OK] ==
                      (m_tdata[OFF_CRC_RX +: CRC_W] == m_tdata[OFF_CRC_COMP +: CRC_W])))
        else $error("crc_ok disagrees with the CRC fields");

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("back stage took an item from an empty queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule
`default_nettype wire

@@ tb/sv/adc_frame_receiver_crc16_checker.sv @@
module adc_frame_receiver_crc16_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                      s_tuser,   // [0] frame_start
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // response_word, sample_ch0..3, crc_received, crc_computed, crc_ok,
    // frames_seen, crc_failures; zero fill to 216 bits
    input  wire logic [afrc_pkg::TDATA_BITS-1:0] m_tdata,
    output int                                   mismatches,
    output int                                   frames_pending
);
    import afrc_pkg::*;

    localparam int unsigned FRAME_BYTES = (CHANNELS + 2) * WORD_BYTES;
    localparam int unsigned CRC_BYTES   = (CHANNELS + 1) * WORD_BYTES;

    typedef struct packed {
        logic [15:0]      response;
        logic [3:0][23:0] samples;
        logic [15:0]      crc_rx;
        logic [15:0]      crc_comp;
        logic             crc_ok;
        logic [31:0]      frames;
        logic [31:0]      fails;
    } frame_result_t;

    logic [4:0]    byte_pos;
    logic [15:0]   crc_acc;
    logic [15:0]   resp_hold;
    logic [23:0]   chan_hold [4];
    logic [15:0]   crc_hold;
    logic [31:0]   frame_count;
    logic [31:0]   error_count;
    frame_result_t expected_frames [$];
    int            results_seen;

    // bit-serial form: feedback is the top CRC bit xor the incoming data bit
    function automatic logic [15:0] crc16_ccitt_bits(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input logic start);
        int unsigned   pos;
        int unsigned   word;
        int unsigned   sub;
        frame_result_t r;
        if (start || byte_pos >= FRAME_BYTES) begin
            byte_pos = '0;
            crc_acc  = CRC_SEED;
        end
        pos  = byte_pos;
        word = pos / WORD_BYTES;
        sub  = pos % WORD_BYTES;
        // padding byte of the response word still enters the CRC
        if (pos < CRC_BYTES) begin
            crc_acc = crc16_ccitt_bits(crc_acc, b);
        end
        if (word == 0) begin
            if (sub == 0) begin
                resp_hold[15:8] = b;
            end else if (sub == 1) begin
                resp_hold[7:0] = b;
            end
        end else if (word <= CHANNELS) begin
            chan_hold[word - 1][(2 - sub) * 8 +: 8] = b;
        end else begin
            if (sub == 0) begin
                crc_hold[15:8] = b;
            end else if (sub == 1) begin
                crc_hold[7:0] = b;
            end
        end
        if (pos + 1 < FRAME_BYTES) begin
            byte_pos = 5'(pos + 1);
        end else begin
            frame_count = frame_count + 1;
            if (crc_hold != crc_acc) begin
                error_count = error_count + 1;
            end
            r.response = resp_hold;
            for (int c = 0; c < 4; c++) begin
                r.samples[c] = (c < CHANNELS) ? chan_hold[c] : 24'h0;
            end
            r.crc_rx   = crc_hold;
            r.crc_comp = crc_acc;
            r.crc_ok   = (crc_hold == crc_acc);
            r.frames   = frame_count;
            r.fails    = error_count;
            expected_frames.push_back(r);
            byte_pos = '0;
            crc_acc  = CRC_SEED;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        frame_result_t want;
        frame_result_t got;
        if (!aresetn) begin
            byte_pos    = '0;
            crc_acc     = CRC_SEED;
            resp_hold   = '0;
            crc_hold    = '0;
            frame_count = '0;
            error_count = '0;
            for (int c = 0; c < 4; c++) begin
                chan_hold[c] = '0;
            end
            expected_frames.delete();
        end else begin
            // push first: a result in the same cycle still pops the oldest item
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, s_tuser[0]);
            end
            if (m_tvalid && m_tready) begin
                got.response = m_tdata[OFF_RESP +: RESP_W];
                for (int c = 0; c < 4; c++) begin
                    got.samples[c] = m_tdata[OFF_CH0 + c * SAMPLE_W +: SAMPLE_W];
                end
                got.crc_rx   = m_tdata[OFF_CRC_RX +: CRC_W];
                got.crc_comp = m_tdata[OFF_CRC_COMP +: CRC_W];
                got.crc_ok   = m_tdata[OFF_CRC_OK];
                got.frames   = m_tdata[OFF_FRAMES +: COUNT_OUT_W];
                got.fails    = m_tdata[OFF_FAILS +: COUNT_OUT_W];
                if (expected_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with no frame outstanding: %h",
                                 results_seen, m_tdata);
                    end
                end else begin
                    want = expected_frames.pop_front();
                    check_field("response_word", 32'(want.response), 32'(got.response));
                    check_field("sample_ch0", 32'(want.samples[0]), 32'(got.samples[0]));
                    check_field("sample_ch1", 32'(want.samples[1]), 32'(got.samples[1]));
                    check_field("sample_ch2", 32'(want.samples[2]), 32'(got.samples[2]));
                    check_field("sample_ch3", 32'(want.samples[3]), 32'(got.samples[3]));
                    check_field("crc_received", 32'(want.crc_rx), 32'(got.crc_rx));
                    check_field("crc_computed", 32'(want.crc_comp), 32'(got.crc_comp));
                    check_field("crc_ok", 32'(want.crc_ok), 32'(got.crc_ok));
                    check_field("frames_seen", want.frames, got.frames);
                    check_field("crc_failures", want.fails, got.fails);
                end
                results_seen++;
            end
        end
        frames_pending <= expected_frames.size();
    end

endmodule

@@ tb/sv/adc_frame_receiver_crc16_tb.sv @@
module adc_frame_receiver_crc16_tb;
    import afrc_pkg::*;

    localparam int FRAME_BYTES     = (CHANNELS + 2) * WORD_BYTES;
    localparam int CRC_BYTES       = (CHANNELS + 1) * WORD_BYTES;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int HOLD_CYCLES     = 400;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;  // [7:0] rx_byte
    logic [0:0]            s_tuser  = 1'b0;   // [0] frame_start
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // response_word, sample_ch0..3, crc_received, crc_computed, crc_ok,
    // frames_seen, crc_failures; zero fill to 216 bits
    logic [TDATA_BITS-1:0] m_tdata;
    int                    mismatches;
    int                    frames_pending;

    int   stall_pct     = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;
    int   send_idle_pct = 0;
    int   items_sent    = 0;
    bit   aligned       = 1'b1;
    logic [7:0] frame_buf [FRAME_BYTES];

    int send_idle_by_phase [4] = '{0, 72, 0, 11};
    int stall_by_phase     [4] = '{0, 0, 72, 11};

    adc_frame_receiver_crc16 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    adc_frame_receiver_crc16_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic start);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_frame_bytes(input int count, input logic start);
        for (int i = 0; i < count; i++) begin
            push_byte(frame_buf[i], (i == 0) ? start : 1'b0);
        end
    endtask

    // fills the CRC word from the bytes already in frame_buf
    task automatic seal_frame(input bit good_crc);
        logic [15:0] crc;
        crc = CRC_SEED;
        for (int i = 0; i < CRC_BYTES; i++) begin
            crc = crc_byte(crc, frame_buf[i]);
        end
        if (!good_crc) begin
            if ($urandom_range(1) == 0) begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end else begin
                crc = 16'($urandom);
            end
        end
        frame_buf[CRC_BYTES]     = crc[15:8];
        frame_buf[CRC_BYTES + 1] = crc[7:0];
    endtask

    task automatic random_traffic();
        int   pick;
        int   cut;
        int   n;
        logic start;
        pick = $urandom_range(99);
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_buf[i] = 8'($urandom);
        end
        if (pick < 75) begin
            seal_frame($urandom_range(3) != 0);
            // once aligned, the next frame may follow on without the start flag
            start = aligned ? 1'($urandom_range(1)) : 1'b1;
            send_frame_bytes(FRAME_BYTES, start);
            aligned = 1'b1;
        end else if (pick < 88) begin
            seal_frame(1'b1);
            cut = $urandom_range(FRAME_BYTES - 1, 1);
            send_frame_bytes(cut, 1'b1);
            aligned = 1'b0;
        end else begin
            n = $urandom_range(6, 1);
            repeat (n) push_byte(8'($urandom), 1'($urandom_range(3) == 0));
            aligned = 1'b0;
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // partial frame, restarted mid-way, then abandoned by a fresh start
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b1);
        push_byte(8'h34, 1'b0);
        // full-scale samples: min, max, minus one, zero
        frame_buf = '{8'hFF, 8'hFF, 8'h00,
                      8'h80, 8'h00, 8'h00,
                      8'h7F, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'hFF};
        seal_frame(1'b1);
        send_frame_bytes(FRAME_BYTES, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_idle_by_phase[ph];
            stall_pct    <= stall_by_phase[ph];
            // long hold-off while the sender streams flat out
            if (ph == 0) begin
                hold_requests <= hold_requests + 1;
            end
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                random_traffic();
            end
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (frames_pending != 0);
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0 && frames_pending == 0) begin
            $display("[adc_frame_receiver_crc16] OK");
        end else begin
            $display("[adc_frame_receiver_crc16] ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[adc_frame_receiver_crc16] ERROR");
        $finish;
    end

endmodule
